// ===== src/secs1_pkg.sv =====
// ---------------------------------------------------------------------------
// secs1_pkg
// shared types, register indexes and header helpers of the SECS-I framer
// ---------------------------------------------------------------------------
package secs1_pkg;

    localparam int unsigned HDR_BYTES = 10;
    localparam int unsigned HDR_IDX_W = 4;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

    localparam logic [2:0] REG_DEVICE_ID   = 3'd0;
    localparam logic [2:0] REG_FLAGS       = 3'd1;
    localparam logic [2:0] REG_STREAM      = 3'd2;
    localparam logic [2:0] REG_FUNCTION    = 3'd3;
    localparam logic [2:0] REG_BLOCK       = 3'd4;
    localparam logic [2:0] REG_SYSTEM      = 3'd5;
    localparam logic [2:0] REG_BODY_LENGTH = 3'd6;

    localparam logic [1:0] KIND_LEN  = 2'd0;
    localparam logic [1:0] KIND_HDR  = 2'd1;
    localparam logic [1:0] KIND_BODY = 2'd2;
    localparam logic [1:0] KIND_SUM  = 2'd3;

    localparam logic [7:0] FLAG_BIT = 8'h80;

    typedef struct packed {
        logic [14:0] device_id;
        logic [2:0]  flags;
        logic [6:0]  stream;
        logic [7:0]  func;
        logic [14:0] block;
        logic [31:0] system;
        logic [7:0]  body_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_entry;

    function automatic logic [7:0] eff_length(input logic [7:0] len, input logic [7:0] max_len);
        logic [7:0] n;
        n = (len == 8'd0) ? 8'd1 : len;
        if (n > max_len) begin
            n = max_len;
        end
        return n;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx, input t_cfg c);
        logic [7:0] b;
        case (idx)
            4'd0: b = {c.flags[0], c.device_id[14:8]};
            4'd1: b = c.device_id[7:0];
            4'd2: b = {c.flags[1], c.stream};
            4'd3: b = c.func;
            4'd4: b = {c.flags[2], c.block[14:8]};
            4'd5: b = c.block[7:0];
            4'd6: b = c.system[31:24];
            4'd7: b = c.system[23:16];
            4'd8: b = c.system[15:8];
            4'd9: b = c.system[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== src/secs1_fifo.sv =====
// ---------------------------------------------------------------------------
// secs1_fifo
// small register queue between the byte classifier and the frame sequencer
// ---------------------------------------------------------------------------
module secs1_fifo #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

// ===== src/secs1_front.sv =====
// ---------------------------------------------------------------------------
// secs1_front
// accepts body bytes and tags the first and last byte of each block
// ---------------------------------------------------------------------------
module secs1_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_body_byte,
    input  logic [7:0]        i_len,
    input  logic              i_q_full,
    output logic              o_q_push,
    output secs1_pkg::t_entry o_q_entry
);

    logic [7:0] r_body_count, n_body_count;
    logic [7:0] w_next;
    logic       w_last;

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;
    assign w_next     = r_body_count + 8'd1;
    assign w_last     = (w_next >= i_len);

    assign o_q_entry.data  = i_body_byte;
    assign o_q_entry.first = (r_body_count == 8'd0);
    assign o_q_entry.last  = w_last;

    always_comb begin
        n_body_count = r_body_count;
        if (o_q_push) begin
            n_body_count = w_last ? 8'd0 : w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_count <= 8'd0;
        end else begin
            r_body_count <= n_body_count;
        end
    end

endmodule

// ===== src/secs1_back.sv =====
// ---------------------------------------------------------------------------
// secs1_back
// frame sequencer: length, header, body and checksum bytes into an output register
// ---------------------------------------------------------------------------
module secs1_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  secs1_pkg::t_cfg   i_cfg,
    input  logic [7:0]        i_len,
    input  logic              i_q_empty,
    input  secs1_pkg::t_entry i_q_head,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic [1:0]        o_byte_kind,
    output logic              o_block_done
);

    typedef enum logic [3:0] {
        ST_BODY  = 4'b0001,
        ST_HDR   = 4'b0010,
        ST_SUMHI = 4'b0100,
        ST_SUMLO = 4'b1000
    } t_state;

    t_state                            r_state, n_state;
    logic [secs1_pkg::HDR_IDX_W-1:0]   r_idx, n_idx;
    logic                              r_hdr_sent, n_hdr_sent;
    logic [15:0]                       r_sum, n_sum;
    logic                              r_out_valid, n_out_valid;
    logic [7:0]                        r_out_byte, n_out_byte;
    logic [1:0]                        r_byte_kind, n_byte_kind;
    logic                              r_block_done, n_block_done;
    logic                              w_adv;
    logic [7:0]                        w_hdr;

    assign w_adv = !r_out_valid || i_out_ready;
    assign w_hdr = secs1_pkg::hdr_byte(r_idx, i_cfg);

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_kind  = r_byte_kind;
    assign o_block_done = r_block_done;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_hdr_sent   = r_hdr_sent;
        n_sum        = r_sum;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_byte   = r_out_byte;
        n_byte_kind  = r_byte_kind;
        n_block_done = r_block_done;
        o_q_pop      = 1'b0;
        case (r_state)
            ST_BODY: begin
                if (w_adv && !i_q_empty) begin
                    n_out_valid  = 1'b1;
                    n_block_done = 1'b0;
                    if (i_q_head.first && !r_hdr_sent) begin
                        n_out_byte  = 8'(secs1_pkg::HDR_BYTES + 32'(i_len));
                        n_byte_kind = secs1_pkg::KIND_LEN;
                        n_sum       = 16'd0;
                        n_idx       = '0;
                        n_state     = ST_HDR;
                    end else begin
                        n_out_byte  = i_q_head.data;
                        n_byte_kind = secs1_pkg::KIND_BODY;
                        n_sum       = r_sum + {8'd0, i_q_head.data};
                        n_hdr_sent  = 1'b0;
                        o_q_pop     = 1'b1;
                        if (i_q_head.last) begin
                            n_state = ST_SUMHI;
                        end
                    end
                end
            end
            ST_HDR: begin
                if (w_adv) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = w_hdr;
                    n_byte_kind  = secs1_pkg::KIND_HDR;
                    n_block_done = 1'b0;
                    n_sum        = r_sum + {8'd0, w_hdr};
                    if (r_idx == secs1_pkg::HDR_LAST) begin
                        n_hdr_sent = 1'b1;
                        n_state    = ST_BODY;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_SUMHI: begin
                if (w_adv) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_sum[15:8];
                    n_byte_kind  = secs1_pkg::KIND_SUM;
                    n_block_done = 1'b0;
                    n_state      = ST_SUMLO;
                end
            end
            ST_SUMLO: begin
                if (w_adv) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_sum[7:0];
                    n_byte_kind  = secs1_pkg::KIND_SUM;
                    n_block_done = 1'b1;
                    n_sum        = 16'd0;
                    n_state      = ST_BODY;
                end
            end
            default: begin
                n_state = ST_BODY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BODY;
            r_idx       <= '0;
            r_hdr_sent  <= 1'b0;
            r_sum       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_hdr_sent  <= n_hdr_sent;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_byte_kind  <= n_byte_kind;
        r_block_done <= n_block_done;
    end

endmodule

// ===== src/secs1_block_framer.sv =====
// ---------------------------------------------------------------------------
// secs1_block_framer
// SECS-I block framer: length byte, 10-byte header, body and 16-bit checksum
// a body byte passes the queue and the output register; the first byte of a
// block waits behind the length and header; N body bytes make N+13 bytes
// throughput: one byte per cycle unless the output stalls or the queue is empty
// input takes one byte per cycle while the queue (QUEUE_DEPTH) has room
// reset: synchronous active-low; registers to their defaults, frame state idle
// ---------------------------------------------------------------------------
module secs1_block_framer #(
    parameter int unsigned MAX_BODY    = 244,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_body_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_byte_kind,
    output logic        o_block_done
);

    secs1_pkg::t_cfg   r_cfg;
    secs1_pkg::t_entry w_push_entry, w_head;
    logic [7:0]        w_len;
    logic              w_full, w_empty, w_push, w_pop;

    assign w_len = secs1_pkg::eff_length(r_cfg.body_length, 8'(MAX_BODY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_id   <= 15'd66;
            r_cfg.flags       <= 3'd0;
            r_cfg.stream      <= 7'd0;
            r_cfg.func        <= 8'd0;
            r_cfg.block       <= 15'd1;
            r_cfg.system      <= 32'd0;
            r_cfg.body_length <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                secs1_pkg::REG_DEVICE_ID:   r_cfg.device_id   <= i_cfg_data[14:0];
                secs1_pkg::REG_FLAGS:       r_cfg.flags       <= i_cfg_data[2:0];
                secs1_pkg::REG_STREAM:      r_cfg.stream      <= i_cfg_data[6:0];
                secs1_pkg::REG_FUNCTION:    r_cfg.func        <= i_cfg_data[7:0];
                secs1_pkg::REG_BLOCK:       r_cfg.block       <= i_cfg_data[14:0];
                secs1_pkg::REG_SYSTEM:      r_cfg.system      <= i_cfg_data;
                secs1_pkg::REG_BODY_LENGTH: r_cfg.body_length <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    secs1_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_body_byte (i_body_byte),
        .i_len       (w_len),
        .i_q_full    (w_full),
        .o_q_push    (w_push),
        .o_q_entry   (w_push_entry)
    );

    secs1_fifo #(
        .WIDTH ($bits(secs1_pkg::t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_head),
        .o_empty (w_empty)
    );

    secs1_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_len        (w_len),
        .i_q_empty    (w_empty),
        .i_q_head     (w_head),
        .o_q_pop      (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_kind  (o_byte_kind),
        .o_block_done (o_block_done)
    );

endmodule

// ===== tb/secs1_frame_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// secs1_frame_checker
// watches the body byte and line byte channels of the SECS-I block framer,
// keeps its own copy of the registers and frame state, works out the framed
// line bytes for every body byte transfer and compares each line byte
// transfer field by field against the oldest one still owed
// ---------------------------------------------------------------------------
module secs1_frame_checker #(
    parameter int unsigned MAX_BODY = 244
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_body_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic [1:0]  i_byte_kind,
    input  logic        i_block_done,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       done;
    } t_line_byte;

    t_line_byte  line_q[$];
    t_line_byte  want;

    logic [14:0] dev_id    = 15'd66;
    logic [2:0]  flags     = 3'd0;
    logic [6:0]  stream    = 7'd0;
    logic [7:0]  func      = 8'd0;
    logic [14:0] blk_num   = 15'd1;
    logic [31:0] sys_bytes = 32'd0;
    logic [7:0]  body_len  = 8'd1;
    logic [7:0]  body_cnt  = 8'd0;
    logic [15:0] frame_sum = 16'd0;
    int          fails     = 0;

    task automatic owe_byte(input logic [7:0] d, input logic [1:0] k, input logic dn);
        line_q.push_back('{data: d, kind: k, done: dn});
    endtask

    // line bytes caused by one body byte transfer
    task automatic frame_byte(input logic [7:0] b);
        logic [7:0] len;
        logic [7:0] hdr [secs1_pkg::HDR_BYTES];
        len = (body_len == 8'd0) ? 8'd1 : body_len;
        if (len > 8'(MAX_BODY)) begin
            len = 8'(MAX_BODY);
        end
        if (body_cnt == 8'd0) begin
            hdr[0] = {1'b0, dev_id[14:8]} | (flags[0] ? secs1_pkg::FLAG_BIT : 8'h00);
            hdr[1] = dev_id[7:0];
            hdr[2] = {1'b0, stream} | (flags[1] ? secs1_pkg::FLAG_BIT : 8'h00);
            hdr[3] = func;
            hdr[4] = {1'b0, blk_num[14:8]} | (flags[2] ? secs1_pkg::FLAG_BIT : 8'h00);
            hdr[5] = blk_num[7:0];
            hdr[6] = sys_bytes[31:24];
            hdr[7] = sys_bytes[23:16];
            hdr[8] = sys_bytes[15:8];
            hdr[9] = sys_bytes[7:0];
            owe_byte(8'd10 + len, secs1_pkg::KIND_LEN, 1'b0);
            frame_sum = 16'd0;
            foreach (hdr[i]) begin
                owe_byte(hdr[i], secs1_pkg::KIND_HDR, 1'b0);
                frame_sum = frame_sum + 16'(hdr[i]);
            end
        end
        owe_byte(b, secs1_pkg::KIND_BODY, 1'b0);
        frame_sum = frame_sum + 16'(b);
        body_cnt  = body_cnt + 8'd1;
        if (body_cnt >= len) begin
            owe_byte(frame_sum[15:8], secs1_pkg::KIND_SUM, 1'b0);
            owe_byte(frame_sum[7:0], secs1_pkg::KIND_SUM, 1'b1);
            body_cnt  = 8'd0;
            frame_sum = 16'd0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dev_id    = 15'd66;
            flags     = 3'd0;
            stream    = 7'd0;
            func      = 8'd0;
            blk_num   = 15'd1;
            sys_bytes = 32'd0;
            body_len  = 8'd1;
            body_cnt  = 8'd0;
            frame_sum = 16'd0;
            line_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    secs1_pkg::REG_DEVICE_ID:   dev_id    = i_cfg_data[14:0];
                    secs1_pkg::REG_FLAGS:       flags     = i_cfg_data[2:0];
                    secs1_pkg::REG_STREAM:      stream    = i_cfg_data[6:0];
                    secs1_pkg::REG_FUNCTION:    func      = i_cfg_data[7:0];
                    secs1_pkg::REG_BLOCK:       blk_num   = i_cfg_data[14:0];
                    secs1_pkg::REG_SYSTEM:      sys_bytes = i_cfg_data;
                    secs1_pkg::REG_BODY_LENGTH: body_len  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                frame_byte(i_body_byte);
            end
            if (i_out_valid && i_out_ready) begin
                if (line_q.size() == 0) begin
                    $error("line byte %02h kind %0d with nothing owed", i_out_byte, i_byte_kind);
                    fails++;
                end else begin
                    want = line_q.pop_front();
                    if (i_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, i_out_byte);
                        fails++;
                    end
                    if (i_byte_kind !== want.kind) begin
                        $error("byte_kind: expected %0d, got %0d", want.kind, i_byte_kind);
                        fails++;
                    end
                    if (i_block_done !== want.done) begin
                        $error("block_done: expected %0b, got %0b", want.done, i_block_done);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= line_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// stimulus for the SECS-I block framer: directed frames over register
// extremes, flag bits, length clamping and an unused register index, then
// random frames with random header registers under four idle and stall
// mixes, and an oversized block closed early by a shorter length; the
// checker gives the error count
// ---------------------------------------------------------------------------
module tb_top;

    localparam int          MAX_BODY    = 244;
    localparam int          QUIET_LIMIT = 2000;
    localparam logic [2:0]  REG_UNUSED  = 3'd7;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_idx   = 3'd0;
    logic [31:0] i_cfg_data  = 32'd0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_body_byte = 8'd0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_byte_kind;
    logic        o_block_done;

    int fail_count;
    int pending_bytes;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int quiet_count = 0;
    int sent        = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    secs1_block_framer #(.MAX_BODY(MAX_BODY)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_body_byte  (i_body_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_kind  (o_byte_kind),
        .o_block_done (o_block_done)
    );

    secs1_frame_checker #(.MAX_BODY(MAX_BODY)) frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_body_byte  (i_body_byte),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_byte   (o_out_byte),
        .i_byte_kind  (o_byte_kind),
        .i_block_done (o_block_done),
        .o_fail_count (fail_count),
        .o_pending    (pending_bytes)
    );

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    function automatic int frame_len(input logic [7:0] len);
        if (len == 8'd0) begin
            return 1;
        end
        return (int'(len) > MAX_BODY) ? MAX_BODY : int'(len);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [31:0] dev, input logic [31:0] flg,
                             input logic [31:0] strm, input logic [31:0] fn,
                             input logic [31:0] blk, input logic [31:0] sys,
                             input logic [31:0] len, input bit poke_unused);
        write_reg(secs1_pkg::REG_DEVICE_ID, dev);
        write_reg(secs1_pkg::REG_FLAGS, flg);
        write_reg(secs1_pkg::REG_STREAM, strm);
        write_reg(secs1_pkg::REG_FUNCTION, fn);
        write_reg(secs1_pkg::REG_BLOCK, blk);
        write_reg(secs1_pkg::REG_SYSTEM, sys);
        write_reg(secs1_pkg::REG_BODY_LENGTH, len);
        if (poke_unused) begin
            write_reg(REG_UNUSED, $urandom);
        end
        i_cfg_we <= 1'b0;
    endtask

    // valid stays up after a transfer so back-to-back bytes keep valid high between them
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_body_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_bytes != 0);
    endtask

    task automatic random_block(input logic [7:0] len);
        logic [31:0] upper;
        upper = $urandom;
        set_frame($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  {upper[31:8], len}, $urandom_range(0, 9) == 0);
        repeat (frame_len(len)) send_byte(8'($urandom_range(0, 255)));
        drain();
    endtask

    initial begin
        int          target;
        int          pick;
        logic [7:0]  len;
        int          idle_mix  [4] = '{0, 56, 0, 19};
        int          stall_mix [4] = '{0, 0, 56, 19};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset values
        send_byte(8'h00);
        drain();

        // every header register at its top value, body length two
        set_frame(32'h7FFF, 32'h7, 32'h7F, 32'hFF, 32'h7FFF, 32'hFFFF_FFFF, 32'd2, 1'b0);
        send_byte(8'hFF);
        send_byte(8'h80);
        drain();

        // all zero, body length zero acts as one
        set_frame(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_byte(8'h55);
        drain();

        // write to an unused index is dropped
        set_frame(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 1'b1);
        send_byte(8'hAA);
        drain();

        // one header flag at a time
        for (int f = 1; f <= 4; f = f * 2) begin
            set_frame(32'h2A55, f, 32'h5A, 32'hA5, 32'h55AA, 32'h1234_5678, 32'h1, 1'b0);
            send_byte(8'(f * 33));
            drain();
        end

        set_frame(32'h5A5A, 32'h0, 32'h25, 32'h3C, 32'h2A5A, 32'h89AB_CDEF, 32'h8, 1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        repeat (6) send_byte(8'($urandom_range(0, 255)));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = idle_mix[phase];
            stall_pct = stall_mix[phase];
            target    = sent + 55;
            while (sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    len = 8'd0;
                end else if (pick < 85) begin
                    len = 8'($urandom_range(1, 6));
                end else begin
                    len = 8'($urandom_range(7, 24));
                end
                random_block(len);
            end
        end

        // oversized length clamps, then a shorter length closes the open block
        idle_pct  = 19;
        stall_pct = 19;
        set_frame($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  32'hFF, 1'b0);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        drain();
        write_reg(secs1_pkg::REG_BODY_LENGTH, 32'h2);
        i_cfg_we <= 1'b0;
        send_byte(8'h7E);
        drain();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_bytes == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
